/* src/ipidg_pkg.sv */
package ipidg_pkg;

  // Fraction bits of the gains and of the stored drive value
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int DRIVE_W        = 8 + GAIN_FRAC_BITS;
  localparam int ERR_W          = 9;
  localparam int DIFF1_W        = ERR_W + 1;
  localparam int DIFF2_W        = ERR_W + 2;
  localparam int PROD_W         = GAIN_W + DIFF2_W;
  localparam int ACC_W          = PROD_W + 3;

  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [7:0] REQUEST_CODE = 8'h7E;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT     = 3'd0,
    CFG_GAIN_PROP    = 3'd1,
    CFG_GAIN_INTEG   = 3'd2,
    CFG_GAIN_DERIV   = 3'd3,
    CFG_OUT_MAX      = 3'd4,
    CFG_OUT_MIN      = 3'd5,
    CFG_GLITCH_LIMIT = 3'd6
  } cfg_idx_e;

  localparam logic [6:0]        SETPOINT_RST     = 7'd0;
  localparam logic [GAIN_W-1:0] GAIN_PROP_RST    = 16'd256;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST   = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST   = 16'd0;
  localparam logic [7:0]        OUT_MAX_RST      = 8'd122;
  localparam logic [7:0]        OUT_MIN_RST      = 8'd1;
  localparam logic [7:0]        GLITCH_LIMIT_RST = 8'd100;

  typedef struct packed {
    logic [6:0]               setpoint;
    logic signed [GAIN_W-1:0] gain_prop;
    logic signed [GAIN_W-1:0] gain_integ;
    logic signed [GAIN_W-1:0] gain_deriv;
    logic [7:0]               out_max;
    logic [7:0]               out_min;
    logic [7:0]               glitch_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]              held;
    logic signed [ERR_W-1:0] err1;
    logic signed [ERR_W-1:0] err2;
    logic [DRIVE_W-1:0]      drive;
  } state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       reply;
  } result_t;

endpackage

/* src/incremental_pid_with_glitch_reject.sv */
// Velocity-form PID temperature controller with glitch rejection. Each input word
// is one received byte; each yields exactly one output word, either the control
// value (tuser low) or, for the request byte 0x7E, the setpoint (tuser high).
// Bytes above glitch_limit, but for the request code, are replaced by the last held
// byte before the request check. The block takes one word per clock cycle unless the
// output stalls; a word passes the input register, then the three gain multipliers,
// the sum and the saturation into the output register. The output register lets a new
// word be taken while a result still waits. Write configuration only while idle.
module incremental_pid_with_glitch_reject (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ipidg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ipidg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] sample_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // [7:0] tx_byte
  output logic                             m_axis_tuser    // [0] is_setpoint_reply
);
  import ipidg_pkg::*;

  cfg_t       cfg;
  state_t     state_q, state_d;
  result_t    res;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_data_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;
  logic       s_accept;
  logic       m_accept;

  ipidg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ipidg_step u_step (
    .cfg_i    (cfg),
    .sample_i (in_data_q),
    .state_i  (state_q),
    .result_o (res),
    .state_o  (state_d)
  );

  // move the held word into the output register when that is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = out_valid_q && m_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.tx_byte;
  assign m_axis_tuser  = out_q.reply;

`ifndef SYNTHESIS
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("word advanced but output register not valid");

  a_reply_holds_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.reply |=> state_q.held == REQUEST_CODE)
    else $error("request did not leave the request code held");

  a_reply_keeps_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.reply |=> $stable(state_q.drive) && $stable(state_q.err1)
                            && $stable(state_q.err2))
    else $error("request disturbed the control loop state");

  a_empty_takes_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input register refused a word");
`endif

endmodule

/* src/ipidg_cfg.sv */
module ipidg_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ipidg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ipidg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ipidg_pkg::cfg_t                 cfg_o
);
  import ipidg_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint     <= SETPOINT_RST;
      cfg_q.gain_prop    <= GAIN_PROP_RST;
      cfg_q.gain_integ   <= GAIN_INTEG_RST;
      cfg_q.gain_deriv   <= GAIN_DERIV_RST;
      cfg_q.out_max      <= OUT_MAX_RST;
      cfg_q.out_min      <= OUT_MIN_RST;
      cfg_q.glitch_limit <= GLITCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETPOINT:     cfg_q.setpoint     <= cfg_wdata_i[6:0];
        CFG_GAIN_PROP:    cfg_q.gain_prop    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_INTEG:   cfg_q.gain_integ   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_GAIN_DERIV:   cfg_q.gain_deriv   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_OUT_MAX:      cfg_q.out_max      <= cfg_wdata_i[7:0];
        CFG_OUT_MIN:      cfg_q.out_min      <= cfg_wdata_i[7:0];
        CFG_GLITCH_LIMIT: cfg_q.glitch_limit <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/ipidg_step.sv */
module ipidg_step (
  input  ipidg_pkg::cfg_t    cfg_i,
  input  logic [7:0]         sample_i,
  input  ipidg_pkg::state_t  state_i,
  output ipidg_pkg::result_t result_o,
  output ipidg_pkg::state_t  state_o
);
  import ipidg_pkg::*;

  logic [7:0]                x;
  logic                      reply;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF1_W-1:0] diff1;
  logic signed [DIFF2_W-1:0] diff2;
  logic signed [PROD_W-1:0]  p_prop;
  logic signed [PROD_W-1:0]  p_integ;
  logic signed [PROD_W-1:0]  p_deriv;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   hi;
  logic signed [ACC_W-1:0]   lo;
  logic signed [ACC_W-1:0]   u;

  always_comb begin
    // replace a glitch by the last held byte; the request code passes
    if (sample_i > cfg_i.glitch_limit && sample_i != REQUEST_CODE) begin
      x = state_i.held;
    end else begin
      x = sample_i;
    end
    reply = (x == REQUEST_CODE);

    err   = $signed({2'b00, cfg_i.setpoint}) - $signed({1'b0, x});
    diff1 = DIFF1_W'(err) - DIFF1_W'(state_i.err1);
    diff2 = DIFF2_W'(err) - (DIFF2_W'(state_i.err1) <<< 1) + DIFF2_W'(state_i.err2);

    p_prop  = PROD_W'(cfg_i.gain_prop)  * PROD_W'(diff1);
    p_integ = PROD_W'(cfg_i.gain_integ) * PROD_W'(err);
    p_deriv = PROD_W'(cfg_i.gain_deriv) * PROD_W'(diff2);

    acc = ACC_W'($signed({1'b0, state_i.drive})) + ACC_W'(p_prop)
        + ACC_W'(p_integ) + ACC_W'(p_deriv);

    hi = ACC_W'($signed({1'b0, cfg_i.out_max, {GAIN_FRAC_BITS{1'b0}}}));
    lo = ACC_W'($signed({1'b0, cfg_i.out_min, {GAIN_FRAC_BITS{1'b0}}}));

    // when the limits cross, a sum above the upper limit gets it and any other the lower
    if (acc > hi) begin
      u = hi;
    end else if (acc < lo) begin
      u = lo;
    end else begin
      u = acc;
    end

    state_o      = state_i;
    state_o.held = x;
    if (reply) begin
      result_o.tx_byte = {1'b0, cfg_i.setpoint};
      result_o.reply   = 1'b1;
    end else begin
      result_o.tx_byte = u[GAIN_FRAC_BITS +: 8];
      result_o.reply   = 1'b0;
      state_o.drive    = u[DRIVE_W-1:0];
      state_o.err1     = err;
      state_o.err2     = state_i.err1;
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import ipidg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 40;
  // outside the register map; a write here must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tuser;

  incremental_pid_with_glitch_reject dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Controller copy: registers and loop state
  cfg_t       ctl_cfg;
  logic [7:0] held_q;
  longint     err1_q;
  longint     err2_q;
  longint     drive_q;
  result_t    expected_tx[$];

  int  err_count   = 0;
  int  cycle_count = 0;
  int  samples_fed = 0;
  int  n_controls  = 0;
  int  n_replies   = 0;
  int  n_settings  = 0;
  bit  idle_en     = 1'b0;
  int  burst_left  = 0;
  int  stall_pct   = 0;
  int  stall_left  = 0;
  int  holds_asked = 0;
  int  holds_taken = 0;
  int  hold_left   = 0;
  result_t tx_want;

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) begin
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
    end
    err_count++;
  endtask

  function automatic result_t controller_step(input logic [7:0] raw);
    logic [7:0] x;
    longint     e;
    longint     u;
    longint     hi;
    longint     lo;
    longint     one;
    result_t    r;
    one = longint'(1) << GAIN_FRAC_BITS;
    x = raw;
    // glitch: reuse last held byte, which may itself be the request code
    if (x > ctl_cfg.glitch_limit && x != REQUEST_CODE) x = held_q;
    held_q = x;
    if (x == REQUEST_CODE) begin
      r.tx_byte = {1'b0, ctl_cfg.setpoint};
      r.reply   = 1'b1;
      return r;
    end
    e = longint'(ctl_cfg.setpoint) - longint'(x);
    u = drive_q
        + longint'($signed(ctl_cfg.gain_prop)) * (e - err1_q)
        + longint'($signed(ctl_cfg.gain_integ)) * e
        + longint'($signed(ctl_cfg.gain_deriv)) * (e - 2 * err1_q + err2_q);
    hi = longint'(ctl_cfg.out_max) * one;
    lo = longint'(ctl_cfg.out_min) * one;
    // crossed limits: a sum above the upper limit gets it, any other the lower one
    if (u > hi) u = hi;
    else if (u < lo) u = lo;
    drive_q = u;
    err2_q  = err1_q;
    err1_q  = e;
    r.tx_byte = 8'(u >>> GAIN_FRAC_BITS);
    r.reply   = 1'b0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_tx.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_tx.size() == 0) begin
        report_mismatch($sformatf("unexpected word tx=%02h reply=%0b", m_axis_tdata,
                                  m_axis_tuser));
      end else begin
        tx_want = expected_tx.pop_front();
        if (m_axis_tdata !== tx_want.tx_byte) begin
          report_mismatch($sformatf("tx_byte %02h, want %02h", m_axis_tdata,
                                    tx_want.tx_byte));
        end
        if (m_axis_tuser !== tx_want.reply) begin
          report_mismatch($sformatf("reply flag %0b, want %0b", m_axis_tuser,
                                    tx_want.reply));
        end
        if (tx_want.reply) n_replies++;
        else n_controls++;
      end
    end
  end

  // Receiver: short random stall runs, plus long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      m_axis_tready <= 1'b0;
      holds_taken   <= holds_taken + 1;
      hold_left     <= HOLD_CYCLES;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [7:0] b);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_tx.push_back(controller_step(b));
    samples_fed++;
  endtask

  task automatic feed_sample(input logic [7:0] b);
    send_sample(b);
    if (idle_en) begin
      if (burst_left == 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drop valid and wait until every word in flight has come out
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_tx.size() == 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_SETPOINT:     ctl_cfg.setpoint     = data[6:0];
      CFG_GAIN_PROP:    ctl_cfg.gain_prop    = data;
      CFG_GAIN_INTEG:   ctl_cfg.gain_integ   = data;
      CFG_GAIN_DERIV:   ctl_cfg.gain_deriv   = data;
      CFG_OUT_MAX:      ctl_cfg.out_max      = data[7:0];
      CFG_OUT_MIN:      ctl_cfg.out_min      = data[7:0];
      CFG_GLITCH_LIMIT: ctl_cfg.glitch_limit = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain(input bit corner);
    int sel;
    sel = $urandom_range(0, 7);
    if (corner) begin
      case (sel % 4)
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'h0100;
      endcase
    end
    if (sel == 0) return 16'($urandom);
    return 16'($urandom_range(0, 768)) - 16'd256;
  endfunction

  task automatic randomize_settings(input bit corner);
    logic [6:0] sp;
    logic [7:0] omax;
    logic [7:0] omin;
    logic [7:0] glim;
    logic [7:0] swap;
    if (corner) begin
      sp   = $urandom_range(0, 1) ? 7'd127 : 7'd0;
      omax = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      omin = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      case ($urandom_range(0, 3))
        0: glim = 8'd0;
        1: glim = 8'd255;
        2: glim = REQUEST_CODE;
        default: glim = REQUEST_CODE - 8'd1;
      endcase
    end else begin
      sp   = 7'($urandom_range(10, 110));
      omax = 8'($urandom_range(60, 255));
      omin = 8'($urandom_range(0, 60));
      glim = 8'($urandom_range(60, 255));
      if ($urandom_range(0, 9) == 0) begin
        swap = omax;
        omax = omin;
        omin = swap;
      end
    end
    // upper data bits above a narrow register are junk and must be dropped
    write_reg(CFG_SETPOINT, {9'($urandom), sp});
    write_reg(CFG_GAIN_PROP, pick_gain(corner));
    write_reg(CFG_GAIN_INTEG, pick_gain(corner));
    write_reg(CFG_GAIN_DERIV, pick_gain(corner));
    write_reg(CFG_OUT_MAX, {8'($urandom), omax});
    write_reg(CFG_OUT_MIN, {8'($urandom), omin});
    write_reg(CFG_GLITCH_LIMIT, {8'($urandom), glim});
    n_settings++;
  endtask

  function automatic logic [7:0] pick_sample();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 12) return REQUEST_CODE;
    if (sel < 50) return 8'($urandom_range(0, 255));
    v = int'(ctl_cfg.setpoint) + int'($urandom_range(0, 40)) - 20;
    if (v < 0) v = 0;
    return 8'(v);
  endfunction

  task automatic test_reset_values();
    idle_en   = 1'b0;
    stall_pct = 0;
    n_settings++;
    send_sample(8'd0);
    send_sample(8'd100);
    send_sample(8'd101);
    send_sample(REQUEST_CODE);
    send_sample(8'd200);
    send_sample(8'd50);
    send_sample(8'd255);
  endtask

  task automatic test_corner_settings();
    write_reg(CFG_SETPOINT, 16'd127);
    write_reg(CFG_GAIN_PROP, 16'h7FFF);
    write_reg(CFG_GAIN_INTEG, 16'h7FFF);
    write_reg(CFG_GAIN_DERIV, 16'h8000);
    write_reg(CFG_OUT_MAX, 16'd255);
    write_reg(CFG_OUT_MIN, 16'd0);
    write_reg(CFG_GLITCH_LIMIT, 16'd255);
    n_settings++;
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(REQUEST_CODE);
    send_sample(8'h7F);
    send_sample(8'h7D);
    send_sample(8'h00);
    // crossed limits
    write_reg(CFG_OUT_MAX, 16'd50);
    write_reg(CFG_OUT_MIN, 16'd200);
    write_reg(CFG_GAIN_PROP, 16'h8000);
    write_reg(CFG_GAIN_INTEG, 16'h0000);
    write_reg(CFG_GAIN_DERIV, 16'h7FFF);
    write_reg(CFG_SETPOINT, 16'd0);
    n_settings++;
    send_sample(8'd10);
    send_sample(8'd200);
    send_sample(8'd0);
    // every nonzero byte but the request code is a glitch; a held request code turns glitches into requests
    write_reg(CFG_GLITCH_LIMIT, 16'd0);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    n_settings++;
    send_sample(8'd1);
    send_sample(REQUEST_CODE);
    send_sample(8'd5);
    send_sample(8'd0);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      randomize_settings(phase == 0 || phase == 5);
      idle_en   = (phase != 2);
      stall_pct = (phase == 3) ? 0 : $urandom_range(5, 40);
      repeat (280) feed_sample(pick_sample());
    end
  endtask

  task automatic test_steady_stream();
    randomize_settings(1'b0);
    idle_en   = 1'b0;
    stall_pct = 0;
    repeat (150) feed_sample(pick_sample());
  endtask

  // Receiver holds off while the sender keeps offering; input must stall
  task automatic test_backpressure();
    randomize_settings(1'b0);
    idle_en   = 1'b0;
    stall_pct = 0;
    holds_asked++;
    repeat (80) feed_sample(pick_sample());
    stall_pct = 20;
    idle_en   = 1'b1;
    holds_asked++;
    repeat (80) feed_sample(pick_sample());
  endtask

  initial begin
    ctl_cfg.setpoint     = SETPOINT_RST;
    ctl_cfg.gain_prop    = GAIN_PROP_RST;
    ctl_cfg.gain_integ   = GAIN_INTEG_RST;
    ctl_cfg.gain_deriv   = GAIN_DERIV_RST;
    ctl_cfg.out_max      = OUT_MAX_RST;
    ctl_cfg.out_min      = OUT_MIN_RST;
    ctl_cfg.glitch_limit = GLITCH_LIMIT_RST;
    held_q  = '0;
    err1_q  = 0;
    err2_q  = 0;
    drive_q = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_corner_settings();
    test_random_traffic();
    test_steady_stream();
    test_backpressure();

    drain_pipeline();
    repeat (10) @(posedge clk_i);
    if (expected_tx.size() != 0) begin
      report_mismatch($sformatf("%0d words never arrived", expected_tx.size()));
    end
    $display("Fed %0d samples over %0d register settings (%0d long receiver hold-offs)",
             samples_fed, n_settings, holds_taken);
    $display("Checked %0d control words and %0d setpoint replies, %0d mismatches",
             n_controls, n_replies, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
